FILE: rtl/gdad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdad_pkg: shared types and constants for the Gregorian date adder
// Sizes, calendar tables, the sequencer state type and the leap-year rule.
// ----------------------------------------------------------------------------
package gdad_pkg;

   // Internal widths of the day count and the year
   localparam int DAY_COUNT_BITS = 16;
   localparam int YEAR_BITS      = 14;

   // Fixed field widths on the stream ports
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int ADD_W   = 16;

   // Day of year plus day count, and the width of the shared subtractor
   localparam int DOY_BITS  = ((DAY_COUNT_BITS > 9) ? DAY_COUNT_BITS : 9) + 1;
   localparam int UNIT_BITS = (DOY_BITS > YEAR_BITS) ? DOY_BITS : YEAR_BITS;

   // Year reduction modulo 400: 400 << (YEAR_BITS-8) exceeds any year
   localparam int MOD_BASE  = 400;
   localparam int MOD_STEPS = YEAR_BITS - 8;
   localparam int STEP_W    = $clog2(MOD_STEPS);

   localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;

   localparam int MONTHS   = 12;
   localparam int MON_IDX_W = $clog2(MONTHS);
   localparam logic [MON_IDX_W-1:0] MON_FEB  = MON_IDX_W'(1);
   localparam logic [MON_IDX_W-1:0] MON_NOV  = MON_IDX_W'(10);
   localparam logic [MON_IDX_W-1:0] MON_DEC  = MON_IDX_W'(11);

   localparam logic [8:0] LEN_YEAR      = 9'd365;
   localparam logic [8:0] LEN_LEAP_YEAR = 9'd366;
   localparam logic [4:0] LEN_LEAP_FEB  = 5'd29;

   // Days in the year before the first of each month (common year)
   localparam logic [8:0] DAYS_BEFORE [MONTHS] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // Month lengths (common year)
   localparam logic [4:0] MONTH_LEN [MONTHS] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_BASE,
      ST_YEARS,
      ST_MONTHS,
      ST_DONE
   } gdad_state_type;

   // Compare flags from the shared subtractor
   typedef struct packed {
      logic ge;
      logic gt;
   } gdad_cmp_type;

   // Leap rule on the year modulo 400
   function automatic logic leap_of(input logic [8:0] r400);
      return (r400[1:0] == 2'b00) && (r400 != 9'd100) && (r400 != 9'd200)
             && (r400 != 9'd300);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/gdad_sub.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdad_sub: shared compare and subtract unit
// Gives a - b and whether a >= b and a > b, for the modulo, year and month steps.
// ----------------------------------------------------------------------------
module gdad_sub
   import gdad_pkg::*;
(
   input  wire logic [UNIT_BITS-1:0] minuend,
   input  wire logic [UNIT_BITS-1:0] subtrahend,
   output logic      [UNIT_BITS-1:0] diff,
   output gdad_cmp_type              cmp
);

   logic borrow;

   // Subtract with borrow out
   assign {borrow, diff} = {1'b0, minuend} - {1'b0, subtrahend};

   // Derive the compare flags
   always_comb begin
      cmp.ge = ~borrow;
      cmp.gt = ~borrow && (diff != '0);
   end

endmodule
`default_nettype wire

FILE: rtl/gregorian_date_add_days.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence from accept to result: ST_MOD reduces the year modulo 400, ST_BASE forms the
//   day of year, ST_YEARS steps off whole years, ST_MONTHS steps months, ST_DONE loads the result.
// Throughput: one transaction at a time; one shared subtractor does every compare step.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_tvalid.
// ----------------------------------------------------------------------------
// gregorian_date_add_days: advance a Gregorian date by a count of days
// Reduces the year modulo 400, forms the day of year, steps off whole years
// and then months with one shared subtractor; saturates on year overflow.
// ----------------------------------------------------------------------------
module gregorian_date_add_days
   import gdad_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // start_day[4:0], start_month[8:5], start_year[22:9], days_to_add[38:23], zero pad
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // result_day[4:0], result_month[8:5], result_year[22:9], zero pad
   output logic [23:0]      rsp_tdata,
   // year_overflow[0]
   output logic [0:0]       rsp_tuser
);

   gdad_state_type state_ff, state_in;

   logic [DAY_W-1:0]          day_ff, day_in;
   logic [MON_IDX_W-1:0]      mon_ff, mon_in;
   logic [DAY_COUNT_BITS-1:0] add_ff, add_in;
   logic [YEAR_BITS-1:0]      year_ff, year_in;
   logic [YEAR_BITS-1:0]      rem_ff, rem_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [DOY_BITS-1:0]       doy_ff, doy_in;
   logic                      over_ff, over_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DAY_W-1:0]          rsp_day_ff;
   logic [MONTH_W-1:0]        rsp_month_ff;
   logic [YEAR_W-1:0]         rsp_year_ff;
   logic                      rsp_over_ff;

   logic [DAY_W-1:0]          f_day;
   logic [MONTH_W-1:0]        f_month;
   logic [YEAR_W-1:0]         f_year;
   logic [ADD_W-1:0]          f_add;

   logic [UNIT_BITS-1:0]      op_a, op_b, sub_diff;
   gdad_cmp_type              sub_cmp;
   logic                      leap;
   logic [4:0]                mlen;
   logic                      accept, load_out;

   assign f_day   = req_tdata[4:0];
   assign f_month = req_tdata[8:5];
   assign f_year  = req_tdata[22:9];
   assign f_add   = req_tdata[38:23];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load_out   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Leap flag and month length from the year modulo 400
   assign leap = leap_of(rem_ff[8:0]);
   assign mlen = ((mon_ff == MON_FEB) && leap) ? LEN_LEAP_FEB : MONTH_LEN[mon_ff];

   // Pick the operands of the shared unit by state
   always_comb begin
      case (state_ff)
         ST_MOD: begin
            op_a = UNIT_BITS'(rem_ff);
            op_b = UNIT_BITS'(MOD_BASE) << step_ff;
         end
         ST_YEARS: begin
            op_a = UNIT_BITS'(doy_ff);
            op_b = UNIT_BITS'(leap ? LEN_LEAP_YEAR : LEN_YEAR);
         end
         default: begin
            op_a = UNIT_BITS'(doy_ff);
            op_b = UNIT_BITS'(mlen);
         end
      endcase
   end

   gdad_sub u_sub (
      .minuend    (op_a),
      .subtrahend (op_b),
      .diff       (sub_diff),
      .cmp        (sub_cmp)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_MOD;
         ST_MOD:    if (step_ff == '0) state_in = ST_BASE;
         ST_BASE:   state_in = ST_YEARS;
         ST_YEARS: begin
            if (!sub_cmp.gt) state_in = ST_MONTHS;
            else if (year_ff == YEAR_MAX) state_in = ST_DONE;
         end
         ST_MONTHS: if ((mon_ff == MON_DEC) || !sub_cmp.gt) state_in = ST_DONE;
         ST_DONE:   if (load_out) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath updates per state
   always_comb begin
      day_in  = day_ff;
      mon_in  = mon_ff;
      add_in  = add_ff;
      year_in = year_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      doy_in  = doy_ff;
      over_in = over_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               day_in  = (f_day == '0) ? DAY_W'(1) : f_day;
               mon_in  = ((f_month == '0) || (f_month > MONTH_W'(MONTHS))) ?
                         '0 : MON_IDX_W'(f_month - MONTH_W'(1));
               add_in  = DAY_COUNT_BITS'(f_add);
               year_in = YEAR_BITS'(f_year);
               rem_in  = YEAR_BITS'(f_year);
               step_in = STEP_W'(MOD_STEPS - 1);
               over_in = 1'b0;
            end
         end
         ST_MOD: begin
            if (sub_cmp.ge) rem_in = YEAR_BITS'(sub_diff);
            step_in = step_ff - STEP_W'(1);
         end
         ST_BASE: begin
            doy_in = DOY_BITS'(add_ff) + DOY_BITS'(DAYS_BEFORE[mon_ff])
                     + DOY_BITS'(day_ff)
                     + DOY_BITS'(((mon_ff > MON_FEB) || (mon_ff == MON_FEB + 1'b1))
                                 && (mon_ff > MON_FEB) && leap);
         end
         ST_YEARS: begin
            if (sub_cmp.gt) begin
               doy_in = DOY_BITS'(sub_diff);
               if (year_ff == YEAR_MAX) begin
                  over_in = 1'b1;
               end else begin
                  year_in = year_ff + YEAR_BITS'(1);
                  rem_in  = (rem_ff == YEAR_BITS'(MOD_BASE - 1)) ? '0 :
                            rem_ff + YEAR_BITS'(1);
               end
            end else begin
               mon_in = '0;
            end
         end
         ST_MONTHS: begin
            if ((mon_ff != MON_DEC) && sub_cmp.gt) begin
               doy_in = DOY_BITS'(sub_diff);
               mon_in = mon_ff + MON_IDX_W'(1);
            end
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   // Output valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      day_ff  <= day_in;
      mon_ff  <= mon_in;
      add_ff  <= add_in;
      year_ff <= year_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      doy_ff  <= doy_in;
      over_ff <= over_in;
   end

   // Result register, saturated on overflow
   always_ff @(posedge clock) begin
      if (load_out) begin
         if (over_ff) begin
            rsp_day_ff   <= DAY_W'(31);
            rsp_month_ff <= MONTH_W'(MONTHS);
            rsp_year_ff  <= YEAR_W'(YEAR_MAX);
         end else begin
            rsp_day_ff   <= DAY_W'(doy_ff);
            rsp_month_ff <= MONTH_W'(mon_ff) + MONTH_W'(1);
            rsp_year_ff  <= YEAR_W'(year_ff);
         end
         rsp_over_ff <= over_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_year_ff, rsp_month_ff, rsp_day_ff};
   assign rsp_tuser  = rsp_over_ff;

   // Result month is always a calendar month
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[8:5] >= 4'd1) && (rsp_tdata[8:5] <= 4'd12))
      else $error("result month out of range");

   // Result day is never zero
   a_day_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:0] != 5'd0))
      else $error("result day is zero");

   // Overflow always carries the saturated year
   a_sat_year: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[22:9] == YEAR_W'(YEAR_MAX)))
      else $error("overflow without saturated year");

   // Year residue stays below 400 while stepping years
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_YEARS) |-> (rem_ff < YEAR_BITS'(MOD_BASE)))
      else $error("year residue out of range");

   // Request side is closed while a transaction is in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted while busy");

endmodule
`default_nettype wire
